// ===== sv/bsc_pkg.sv =====
// package with shared types and constants for the barometric compensation block
package bsc_pkg;

    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 48;
    localparam int InDataW   = 24;
    localparam int OutDataW  = 40;
    localparam int DivW      = 64;

    localparam logic [CfgIdxW-1:0] REG_TEMP    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_A = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_B = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_C = 2'd3;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] RAW_FULL    = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [31:0] TEMP_ROUND  = 32'd128;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
        ST_DIV_START, ST_DIV_WAIT,
        ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4,
        ST_OUT
    } bsc_state_t;

    typedef struct packed {
        logic start;
        logic neg;
    } div_ctl_t;

endpackage

// ===== sv/bsc_mul.sv =====
// shared 64-bit wrapping multiplier built from 32x32 partial products over cycles
module bsc_mul
    import bsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] prod
);
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [31:0] ma, mb;
    logic [63:0] pp_reg;
    logic [1:0]  pstep_reg;
    logic        pvalid_reg;
    logic        done_reg;

    always_comb begin
        case (step_reg)
            2'd0: begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            2'd1: begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
            2'd2: begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        pp_reg <= {32'd0, ma} * {32'd0, mb};
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        acc_reg <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (start) begin
            acc_next = '0;
        end else if (pvalid_reg) begin
            case (pstep_reg)
                2'd0: acc_next = acc_reg + pp_reg;
                default: acc_next = acc_reg + {pp_reg[31:0], 32'd0};
            endcase
        end
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end else if (busy_reg) begin
            if (step_reg == 2'd2) busy_next = 1'b0;
            else step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            pvalid_reg <= 1'b0;
            pstep_reg  <= '0;
            done_reg   <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            pvalid_reg <= busy_reg;
            pstep_reg  <= step_reg;
            done_reg   <= pvalid_reg && pstep_reg == 2'd2 && !start;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

// ===== sv/bsc_div.sv =====
// radix-2 restoring divider for 64-bit magnitudes, one bit a cycle
module bsc_div
    import bsc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [DivW-1:0] num,
    input  logic [DivW-1:0] den,
    output logic            done,
    output logic [DivW-1:0] quot
);
    localparam int CntW = $clog2(DivW + 1);
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [DivW-1:0] q_reg, q_next, d_reg;
    logic [DivW:0]   r_reg, r_next, trial;
    logic            busy_reg, busy_next;

    always_comb begin
        trial = {r_reg[DivW-1:0], q_reg[DivW-1]} - {1'b0, d_reg};
        r_next = r_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            r_next = '0;
            q_next = num;
            cnt_next = CntW'(DivW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[DivW]) begin
                r_next = {r_reg[DivW-1:0], q_reg[DivW-1]};
                q_next = {q_reg[DivW-2:0], 1'b0};
            end else begin
                r_next = trial;
                q_next = {q_reg[DivW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg <= r_next;
        q_reg <= q_next;
        if (start) d_reg <= den;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    logic busy_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) busy_d_reg <= 1'b0;
        else busy_d_reg <= busy_reg;
    end

    assign done = busy_d_reg && !busy_reg;
    assign quot = q_reg;
endmodule

// ===== sv/barometric_sensor_compensation.sv =====
// top level: register file, sequencer and shared multiplier and divider
//  channel  | dir | handshake          | payload
//  s_       | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata raw bytes
//  m_       | out | m_tvalid/m_tready  | m_tuser result_mode, m_tdata value/flag
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// the result transaction follows the shared multiply steps of the sequencer and,
// for pressure with a nonzero divisor, the one-bit-a-cycle divider
// reset clears calibration, fine temperature and control; one item at a time,
// s_tready is low from acceptance until the result transaction completes
module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // raw_msb, raw_lsb, raw_xlsb
    input  logic                s_tuser,   // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // value, divide_by_zero, zero fill
    output logic                m_tuser,   // result_mode
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);
    logic [47:0] tcal_reg, pa_reg, pb_reg, pc_reg;
    logic [31:0] fine_reg;
    bsc_state_t  st_reg, st_next;
    logic [19:0] raw_reg;
    logic        mode_reg, dz_reg;
    logic [63:0] x_reg, y_reg, z_reg, w_reg, val_reg;
    logic        mstart;
    logic [63:0] ma, mb, mprod;
    logic        mdone;
    div_ctl_t    dctl;
    logic        neg_reg;
    logic [63:0] dnum, dden, dquot;
    logic        ddone;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcal_reg <= '0; pa_reg <= '0; pb_reg <= '0; pc_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TEMP:    tcal_reg <= cfg_data;
                REG_PRESS_A: pa_reg <= cfg_data;
                REG_PRESS_B: pb_reg <= cfg_data;
                REG_PRESS_C: pc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bsc_mul u_mul (.aclk, .aresetn, .start(mstart), .op_a(ma), .op_b(mb),
                   .done(mdone), .prod(mprod));
    bsc_div u_div (.aclk, .aresetn, .start(dctl.start), .num(dnum), .den(dden),
                   .done(ddone), .quot(dquot));

    logic        wait_reg;
    logic        step_go;
    assign step_go = wait_reg ? mdone : 1'b0;

    // operand selection per step
    logic [63:0] ft64, v1b;
    assign ft64 = {{32{fine_reg[31]}}, fine_reg};
    assign v1b  = ft64 - FINE_OFFSET;

    always_comb begin
        ma = '0; mb = '0;
        case (st_reg)
            ST_T0: begin
                ma = {44'd0, raw_reg} >> 3;
                ma = ma - ({48'd0, tcal_reg[15:0]} << 1);
                mb = sx16(tcal_reg[31:16]);
            end
            ST_T1: begin
                ma = {44'd0, raw_reg} >> 4;
                ma = ma - {48'd0, tcal_reg[15:0]};
                mb = ma;
            end
            ST_T2: begin ma = {{44{x_reg[31]}}, x_reg[31:12]}; mb = sx16(tcal_reg[47:32]); end
            ST_P0: begin ma = v1b; mb = v1b; end
            ST_P1: begin ma = x_reg; mb = sx16(pb_reg[47:32]); end
            ST_P2: begin ma = v1b; mb = sx16(pb_reg[31:16]); end
            ST_P3: begin ma = x_reg; mb = sx16(pa_reg[47:32]); end
            ST_P4: begin ma = v1b; mb = sx16(pa_reg[31:16]); end
            ST_P5: begin ma = z_reg; mb = {48'd0, pa_reg[15:0]}; end
            ST_P6: begin ma = (((RAW_FULL - {44'd0, raw_reg}) << 31) - y_reg); mb = PRESS_SCALE; end
            ST_Q0: begin ma = {{13{val_reg[63]}}, val_reg[63:13]}; mb = ma; end
            ST_Q1: begin ma = x_reg; mb = sx16(pc_reg[47:32]); end
            ST_Q2: begin ma = val_reg; mb = sx16(pc_reg[31:16]); end
            default: ;
        endcase
    end

    logic [63:0] absn, absd;
    assign absn = w_reg[63] ? 64'd0 - w_reg : w_reg;
    assign absd = z_reg[63] ? 64'd0 - z_reg : z_reg;
    assign dnum = absn;
    assign dden = absd;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (s_tvalid) st_next = s_tuser ? ST_P0 : ST_T0;
            ST_T0: if (step_go) st_next = ST_T1;
            ST_T1: if (step_go) st_next = ST_T2;
            ST_T2: if (step_go) st_next = ST_T3;
            ST_T3: st_next = ST_T4;
            ST_T4: st_next = ST_OUT;
            ST_P0: if (step_go) st_next = ST_P1;
            ST_P1: if (step_go) st_next = ST_P2;
            ST_P2: if (step_go) st_next = ST_P3;
            ST_P3: if (step_go) st_next = ST_P4;
            ST_P4: if (step_go) st_next = ST_P5;
            ST_P5: if (step_go) st_next = ST_P7;
            ST_P7: st_next = (z_reg == '0) ? ST_OUT : ST_P6;
            ST_P6: if (step_go) st_next = ST_DIV_START;
            ST_DIV_START: st_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (ddone) st_next = ST_P8;
            ST_P8: st_next = ST_Q0;
            ST_Q0: if (step_go) st_next = ST_Q1;
            ST_Q1: if (step_go) st_next = ST_Q2;
            ST_Q2: if (step_go) st_next = ST_Q3;
            ST_Q3: st_next = ST_Q4;
            ST_Q4: st_next = ST_OUT;
            ST_OUT: if (m_tready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = st_reg == ST_IDLE;
        m_tvalid = st_reg == ST_OUT;
        dctl.start = st_reg == ST_DIV_START;
        dctl.neg = w_reg[63] ^ z_reg[63];
        m_tuser = mode_reg;
        m_tdata = {7'd0, dz_reg, val_reg[31:0]};
        case (st_reg)
            ST_T0, ST_T1, ST_T2, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
            ST_Q0, ST_Q1, ST_Q2: mstart = !wait_reg;
            default: mstart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            wait_reg <= 1'b0;
            fine_reg <= '0;
            neg_reg  <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (mstart) wait_reg <= 1'b1;
            else if (mdone) wait_reg <= 1'b0;
            if (dctl.start) neg_reg <= dctl.neg;
            if (st_reg == ST_T3) fine_reg <= x_reg[31:0] + y_reg[31:0];
        end
    end

    logic [31:0] t_fine;
    assign t_fine = x_reg[31:0] + y_reg[31:0];

    always_ff @(posedge aclk) begin
        case (st_reg)
            ST_IDLE: if (s_tvalid) begin
                raw_reg  <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:20]};
                mode_reg <= s_tuser;
                dz_reg   <= 1'b0;
            end
            ST_T0: if (step_go) y_reg <= {{43{mprod[31]}}, mprod[31:11]};
            ST_T1: if (step_go) x_reg <= mprod;
            ST_T2: if (step_go) x_reg <= {{46{mprod[31]}}, mprod[31:14]};
            ST_T3: x_reg <= {32'd0, t_fine};
            ST_T4: val_reg <= {32'd0, 32'(($signed(x_reg[31:0] * 32'd5 + TEMP_ROUND)) >>> 8)};
            ST_P0: if (step_go) x_reg <= mprod;
            ST_P1: if (step_go) y_reg <= mprod + (sx16(pb_reg[15:0]) << 35);
            ST_P2: if (step_go) y_reg <= y_reg + (mprod << 17);
            ST_P3: if (step_go) z_reg <= $signed(mprod) >>> 8;
            ST_P4: if (step_go) z_reg <= (64'd1 << 47) + z_reg + (mprod << 12);
            ST_P5: if (step_go) z_reg <= $signed(mprod) >>> 33;
            ST_P7: if (z_reg == '0) begin
                dz_reg <= 1'b1;
                val_reg <= '0;
            end
            ST_P6: if (step_go) w_reg <= mprod;
            ST_P8: val_reg <= neg_reg ? 64'd0 - dquot : dquot;
            ST_Q0: if (step_go) x_reg <= mprod;
            ST_Q1: if (step_go) y_reg <= $signed(mprod) >>> 25;
            ST_Q2: if (step_go) z_reg <= $signed(mprod) >>> 19;
            ST_Q3: w_reg <= val_reg + y_reg + z_reg;
            ST_Q4: val_reg <= $unsigned($signed(w_reg) >>> 8) + (sx16(pc_reg[15:0]) << 4);
            default: ;
        endcase
    end
endmodule

// ===== tb/tb_top.sv =====
// testbench for barometric_sensor_compensation: scoreboard class, stream drivers, checks
module tb_top;
    import bsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit        mode;
        bit [31:0] value;
        bit        div_zero;
    } comp_result_t;

    class comp_scoreboard;
        bit [47:0]    cal [4];
        bit [31:0]    fine_t;
        comp_result_t pending_q [$];
        int           n_temp;
        int           n_press;
        int           n_zero;

        function bit [63:0] sx16(bit [15:0] x);
            return {{48{x[15]}}, x};
        endfunction

        function void write_reg(bit [CfgIdxW-1:0] idx, bit [47:0] d);
            cal[idx] = d;
        endfunction

        function bit [31:0] temperature(bit [31:0] raw);
            bit [31:0] t1, t2, t3, a, m, v1, d, e, f, v2, g;
            t1 = {16'b0, cal[REG_TEMP][15:0]};
            t2 = 32'(sx16(cal[REG_TEMP][31:16]));
            t3 = 32'(sx16(cal[REG_TEMP][47:32]));
            a = (raw >> 3) - (t1 << 1);
            m = a * t2;
            v1 = $signed(m) >>> 11;
            d = (raw >> 4) - t1;
            e = d * d;
            e = $signed(e) >>> 12;
            f = e * t3;
            v2 = $signed(f) >>> 14;
            fine_t = v1 + v2;
            g = fine_t * 32'd5 + TEMP_ROUND;
            return $signed(g) >>> 8;
        endfunction

        function bit [31:0] pressure(bit [31:0] raw, output bit zero);
            bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, ft, v1, v2, p, h, t, an, ad, q;
            p1 = {48'b0, cal[REG_PRESS_A][15:0]};
            p2 = sx16(cal[REG_PRESS_A][31:16]);
            p3 = sx16(cal[REG_PRESS_A][47:32]);
            p4 = sx16(cal[REG_PRESS_B][15:0]);
            p5 = sx16(cal[REG_PRESS_B][31:16]);
            p6 = sx16(cal[REG_PRESS_B][47:32]);
            p7 = sx16(cal[REG_PRESS_C][15:0]);
            p8 = sx16(cal[REG_PRESS_C][31:16]);
            p9 = sx16(cal[REG_PRESS_C][47:32]);
            ft = {{32{fine_t[31]}}, fine_t};
            v1 = ft - FINE_OFFSET;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            t = v1 * v1 * p3;
            v1 = $unsigned($signed(t) >>> 8) + ((v1 * p2) << 12);
            t = ((64'd1 << 47) + v1) * p1;
            v1 = $signed(t) >>> 33;
            zero = (v1 == 0);
            if (zero) return 32'd0;
            p = RAW_FULL - {32'b0, raw};
            t = ((p << 31) - v2) * PRESS_SCALE;
            an = t[63] ? -t : t;
            ad = v1[63] ? -v1 : v1;
            q = an / ad;
            p = (t[63] != v1[63]) ? -q : q;
            h = $signed(p) >>> 13;
            t = p9 * h * h;
            v1 = $signed(t) >>> 25;
            t = p8 * p;
            v2 = $signed(t) >>> 19;
            t = p + v1 + v2;
            p = $unsigned($signed(t) >>> 8) + (p7 << 4);
            return p[31:0];
        endfunction

        function void note_input(bit mode, bit [7:0] msb, bit [7:0] lsb, bit [7:0] xlsb);
            bit [31:0]    raw;
            comp_result_t r;
            raw = {12'b0, msb, lsb, xlsb[7:4]};
            r.mode = mode;
            r.div_zero = 1'b0;
            if (mode == 1'b0) begin
                r.value = temperature(raw);
                n_temp++;
            end else begin
                r.value = pressure(raw, r.div_zero);
                n_press++;
                if (r.div_zero) n_zero++;
            end
            pending_q.push_back(r);
        endfunction

        function string check(bit mode, bit [31:0] value, bit div_zero);
            comp_result_t e;
            if (pending_q.size() == 0)
                return $sformatf("unexpected result mode=%0d value=%h", mode, value);
            e = pending_q.pop_front();
            if (e.mode != mode || e.value != value || e.div_zero != div_zero)
                return $sformatf("got mode=%0d value=%h dz=%0d, want mode=%0d value=%h dz=%0d",
                                 mode, value, div_zero, e.mode, e.value, e.div_zero);
            return "";
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    comp_scoreboard sb = new();
    int  n_errors = 0;
    int  n_results = 0;
    bit  no_idle = 0;
    bit  long_hold_req = 0;

    barometric_sensor_compensation dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report(string msg);
        $display("error: %s", msg);
        n_errors++;
    endtask

    task automatic write_cfg(bit [CfgIdxW-1:0] idx, bit [47:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task automatic write_all(bit [47:0] c0, bit [47:0] c1, bit [47:0] c2, bit [47:0] c3);
        write_cfg(REG_TEMP, c0);
        write_cfg(REG_PRESS_A, c1);
        write_cfg(REG_PRESS_B, c2);
        write_cfg(REG_PRESS_C, c3);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_item(bit mode, bit [7:0] msb, bit [7:0] lsb, bit [7:0] xlsb);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {xlsb, lsb, msb};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(mode, msb, lsb, xlsb);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(int n);
        bit [31:0] r;
        repeat (n) begin
            r = $urandom;
            send_item(r[24], r[7:0], r[15:8], r[23:16]);
        end
    endtask

    function automatic bit [47:0] rand48();
        return {$urandom, $urandom};
    endfunction

    // result side: random backpressure plus one long hold on request
    initial begin
        int stall_left;
        string msg;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                msg = sb.check(m_tuser, m_tdata[31:0], m_tdata[32]);
                n_results++;
                if (msg != "") report(msg);
                if (m_tdata[OutDataW-1:33] != 0) report("nonzero fill bits in m_tdata");
            end
            if (long_hold_req) begin
                long_hold_req = 0;
                stall_left = 3000;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                           : $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset calibration: pressure before any temperature, zero divisor
        send_item(1'b1, 8'h80, 8'h00, 8'h00);
        send_item(1'b0, 8'h00, 8'h00, 8'h00);
        send_item(1'b0, 8'hff, 8'hff, 8'hff);
        send_item(1'b1, 8'hff, 8'hff, 8'hf0);
        wait_drained();

        write_all({16'hfc18, 16'h6743, 16'd27504}, {16'd3024, 16'hd643, 16'd36477},
                  {16'hfff9, 16'd140, 16'd2855}, {16'd6000, 16'hc6f8, 16'd15500});
        send_item(1'b1, 8'h65, 8'h5a, 8'hc0);
        send_item(1'b0, 8'h7e, 8'hed, 8'h00);
        send_item(1'b1, 8'h65, 8'h5a, 8'hc0);
        send_item(1'b0, 8'h00, 8'h00, 8'h0f);
        send_item(1'b1, 8'h00, 8'h00, 8'h00);
        send_item(1'b0, 8'hff, 8'hff, 8'hf0);
        send_item(1'b1, 8'hff, 8'hff, 8'hff);
        send_item(1'b0, 8'h80, 8'h08, 8'h80);
        send_item(1'b1, 8'h7f, 8'hf7, 8'h70);
        wait_drained();

        write_all({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        send_item(1'b0, 8'hff, 8'hff, 8'hff);
        send_item(1'b1, 8'h00, 8'h00, 8'h00);
        send_item(1'b1, 8'hff, 8'hff, 8'hff);
        wait_drained();
        write_all({3{16'hffff}}, {3{16'hffff}}, {3{16'hffff}}, {3{16'hffff}});
        send_item(1'b0, 8'h00, 8'h00, 8'h00);
        send_item(1'b1, 8'h00, 8'h00, 8'h00);
        send_item(1'b1, 8'hff, 8'hff, 8'hff);
        wait_drained();

        // random phases across several calibration settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all({16'hfc18, 16'h6743, 16'd27504}, {16'd3024, 16'hd643, 16'd36477},
                             {16'hfff9, 16'd140, 16'd2855}, {16'd6000, 16'hc6f8, 16'd15500});
                1: write_all({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
                2: write_all(rand48(), {rand48() & 48'hffff_ffff_0000}, rand48(), rand48());
                7: write_all('0, '0, '0, '0);
                default: write_all(rand48(), rand48(), rand48(), rand48());
            endcase
            no_idle = (ph == 3);
            if (ph == 4) begin
                send_random(3);
                long_hold_req = 1;
                send_random(10);
            end
            send_random(127);
            if (ph == 5) begin
                wait_drained();
                send_random(5);
            end
            no_idle = 0;
            wait_drained();
        end

        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("covered %0d temperature and %0d pressure items, %0d with zero divisor",
                 sb.n_temp, sb.n_press, sb.n_zero);
        $display("checked %0d results over reset, typical, extreme and random calibrations",
                 n_results);
        if (n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
